// File: hdl/srrw_pkg.sv
package srrw_pkg;

  localparam int SEQ_W      = 32;
  localparam int TAG_W      = 32;
  localparam int MAP_W      = 64;
  localparam int FREE_W     = 7;
  localparam int MAX_WINDOW = 64;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [TAG_W-1:0] payload_tag;
  } in_beat_t;

  typedef struct packed {
    logic              deliver;
    logic [SEQ_W-1:0]  delivered_seq;
    logic [TAG_W-1:0]  delivered_tag;
    logic [SEQ_W-1:0]  cumulative_ack;
    logic [MAP_W-1:0]  ack_bitmap;
    logic [FREE_W-1:0] window_free;
    logic              last;
  } out_beat_t;

endpackage

// File: hdl/srrw_ram.sv
module srrw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/selective_repeat_receive_window_core.sv
// selective-repeat receive window
//
// in channel: one beat per received data packet (seq, payload_tag), taken
// when in_valid_i is high and in_stall_o is low. out channel: result beats
// under out_valid_o / out_stall_i handshake, held stable while stalled.
//
// a packet below the base, at or past base+WINDOW, or already buffered is
// dropped with no result; the block then goes from the check state to idle.
// an accepted packet is stored, then the in-order run at the base is walked
// one valid bit per cycle, the ack bitmap is registered in the BMAP state,
// and each delivery waits in EMIT for a free output register, then takes
// its tag from the single registered read port of the tag RAM in RDWAIT.
// with nothing in order, one status beat is loaded from EMIT instead. the
// block takes the next packet while its last result still sits in the
// output register.
//
// reset clears the base, the buffered count and the per-slot valid flops;
// the tag RAM is not cleared, only entries with a set valid bit are read.
// a stalled receiver freezes the output register and the result walk.
module selective_repeat_receive_window_core #(
  parameter int WINDOW = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  srrw_pkg::in_beat_t   in_beat_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output srrw_pkg::out_beat_t  out_beat_o
);

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = 8;

  // one-hot sequencer
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CHECK  = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_BMAP   = 6'b001000,
    ST_EMIT   = 6'b010000,
    ST_RDWAIT = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // window state
  logic [srrw_pkg::SEQ_W-1:0]  base_q, base_d;
  logic [SLOT_W-1:0]           base_slot_q, base_slot_d;
  logic [srrw_pkg::FREE_W-1:0] cnt_q, cnt_d;
  logic [WINDOW-1:0]           valid_q, valid_d;

  // latched packet
  logic [srrw_pkg::SEQ_W-1:0] seq_q;
  logic [srrw_pkg::TAG_W-1:0] tag_q;

  // run walk and result walk
  logic [CNT_W-1:0]           n_q, n_d;
  logic [CNT_W-1:0]           k_q, k_d;
  logic [SLOT_W-1:0]          rd_slot_q, rd_slot_d;
  logic [srrw_pkg::SEQ_W-1:0] rd_seq_q, rd_seq_d;

  // status shared by every beat of a step
  logic [srrw_pkg::SEQ_W-1:0]  ack_q;
  logic [srrw_pkg::MAP_W-1:0]  map_q;
  logic [srrw_pkg::FREE_W-1:0] free_q;
  logic [srrw_pkg::MAP_W-1:0]  map_d;

  // output register
  logic                out_valid_q, out_valid_d;
  srrw_pkg::out_beat_t out_q, out_d;
  logic                out_load;
  logic                out_free;

  // tag RAM
  logic                       ram_we;
  logic [srrw_pkg::TAG_W-1:0] ram_rdata;

  // check stage
  logic [srrw_pkg::SEQ_W-1:0] off;
  logic [SUM_W-1:0]           slot_sum;
  logic [SLOT_W-1:0]          new_slot;
  logic                       accept_pkt;

  logic in_acc;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // offset into the window and the slot it maps to
  always_comb begin
    off      = seq_q - base_q;
    slot_sum = SUM_W'(base_slot_q) + SUM_W'(off[6:0]);
    if (slot_sum >= SUM_W'(WINDOW)) begin
      slot_sum = slot_sum - SUM_W'(WINDOW);
    end
    new_slot   = slot_sum[SLOT_W-1:0];
    accept_pkt = (seq_q >= base_q) && (off < srrw_pkg::SEQ_W'(WINDOW)) &&
                 !valid_q[new_slot];
  end

  // bitmap: valid bits rotated so bit 0 is the slot of the base
  always_comb begin
    logic [SUM_W-1:0] idx;
    map_d = '0;
    for (int i = 0; i < srrw_pkg::MAP_W; i++) begin
      idx = SUM_W'(base_slot_q) + SUM_W'(i);
      if (idx >= SUM_W'(WINDOW)) begin
        idx = idx - SUM_W'(WINDOW);
      end
      if (i < WINDOW) begin
        map_d[i] = valid_q[idx[SLOT_W-1:0]];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    base_slot_d = base_slot_q;
    cnt_d       = cnt_q;
    valid_d     = valid_q;
    n_d         = n_q;
    k_d         = k_q;
    rd_slot_d   = rd_slot_q;
    rd_seq_d    = rd_seq_q;
    ram_we      = 1'b0;
    out_load    = 1'b0;
    out_d       = out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (accept_pkt) begin
          ram_we            = 1'b1;
          valid_d[new_slot] = 1'b1;
          cnt_d             = cnt_q + srrw_pkg::FREE_W'(1);
          n_d               = '0;
          k_d               = '0;
          rd_slot_d         = base_slot_q;
          rd_seq_d          = base_q;
          state_d           = ST_SCAN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // consume the in-order run one slot per cycle
        if ((n_q < CNT_W'(WINDOW)) && valid_q[base_slot_q]) begin
          valid_d[base_slot_q] = 1'b0;
          cnt_d  = cnt_q - srrw_pkg::FREE_W'(1);
          base_d = base_q + srrw_pkg::SEQ_W'(1);
          if (base_slot_q == SLOT_W'(WINDOW - 1)) begin
            base_slot_d = '0;
          end else begin
            base_slot_d = base_slot_q + SLOT_W'(1);
          end
          n_d = n_q + CNT_W'(1);
        end else begin
          state_d = ST_BMAP;
        end
      end
      ST_BMAP: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          if (n_q == '0) begin
            // nothing in order: one status beat
            out_load             = 1'b1;
            out_d.deliver        = 1'b0;
            out_d.delivered_seq  = '0;
            out_d.delivered_tag  = '0;
            out_d.cumulative_ack = ack_q;
            out_d.ack_bitmap     = map_q;
            out_d.window_free    = free_q;
            out_d.last           = 1'b1;
            state_d              = ST_IDLE;
          end else begin
            state_d = ST_RDWAIT;
          end
        end
      end
      ST_RDWAIT: begin
        out_load             = 1'b1;
        out_d.deliver        = 1'b1;
        out_d.delivered_seq  = rd_seq_q;
        out_d.delivered_tag  = ram_rdata;
        out_d.cumulative_ack = ack_q;
        out_d.ack_bitmap     = map_q;
        out_d.window_free    = free_q;
        out_d.last           = ((k_q + CNT_W'(1)) == n_q);
        k_d                  = k_q + CNT_W'(1);
        rd_seq_d             = rd_seq_q + srrw_pkg::SEQ_W'(1);
        if (rd_slot_q == SLOT_W'(WINDOW - 1)) begin
          rd_slot_d = '0;
        end else begin
          rd_slot_d = rd_slot_q + SLOT_W'(1);
        end
        if ((k_q + CNT_W'(1)) == n_q) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_EMIT;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      base_q      <= '0;
      base_slot_q <= '0;
      cnt_q       <= '0;
      valid_q     <= '0;
      n_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      base_slot_q <= base_slot_d;
      cnt_q       <= cnt_d;
      valid_q     <= valid_d;
      n_q         <= n_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      seq_q <= in_beat_i.seq;
      tag_q <= in_beat_i.payload_tag;
    end
    if (state_q == ST_BMAP) begin
      ack_q  <= base_q - srrw_pkg::SEQ_W'(1);
      map_q  <= map_d;
      free_q <= srrw_pkg::FREE_W'(WINDOW) - cnt_q;
    end
    rd_slot_q <= rd_slot_d;
    rd_seq_q  <= rd_seq_d;
    out_q     <= out_d;
  end

  srrw_ram #(
    .WIDTH (srrw_pkg::TAG_W),
    .DEPTH (WINDOW)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (new_slot),
    .wdata_i (tag_q),
    .raddr_i (rd_slot_q),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  // buffered count tracks the valid flops
  a_cnt_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(cnt_q))
    else $error("buffered count out of step with valid bits");

  // an accepted packet is checked in the next cycle
  a_accept_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_CHECK))
    else $error("accepted packet not checked");

  // the output register is empty while a tag read is in flight
  a_rdwait_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RDWAIT) |-> !out_valid_q)
    else $error("tag read landed on a busy output register");

  // a delivered packet is covered by the cumulative ack it carries
  a_deliver_acked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.deliver) |-> (out_q.delivered_seq <= out_q.cumulative_ack))
    else $error("delivered packet beyond cumulative ack");

endmodule

// File: dv/tb_selective_repeat_receive_window_core.sv
`timescale 1ns / 100ps

module tb_selective_repeat_receive_window_core;

  localparam int WIN = srrw_pkg::MAX_WINDOW;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall_o;
  srrw_pkg::in_beat_t  in_beat = '0;
  logic                out_valid_o;
  logic                out_stall = 1'b0;
  srrw_pkg::out_beat_t out_beat_o;

  selective_repeat_receive_window_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // packets waiting to be sent, and the ack / delivery beats we expect back
  srrw_pkg::in_beat_t  packet_q[$];
  srrw_pkg::out_beat_t delivery_q[$];

  int packets_planned = 0;
  int packets_taken = 0;
  int mismatches = 0;

  // receive window as the block should hold it
  logic [31:0] next_expected = '0;
  logic [63:0] held_map = '0;
  logic [31:0] held_tag [64];
  logic [6:0]  held_count = '0;

  // window tracking on the stimulus side, used to aim packets at the window
  logic [31:0] plan_base = '0;
  logic [63:0] plan_held = '0;

  // per-side idle control; calm stretches run with no gaps at all
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;
  int in_wait = 0;
  int out_wait = 0;

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : int'($urandom_range(0, 14));
  endfunction

  // store one received packet, release the in-order run and queue the ack beats
  task automatic window_accept(input srrw_pkg::in_beat_t pkt);
    logic [32:0] win_end;
    logic [5:0]  slot;
    logic [31:0] run_seq[$];
    logic [31:0] run_tag[$];
    logic [63:0] sack;
    srrw_pkg::out_beat_t beat;
    int          total;
    win_end = {1'b0, next_expected} + 33'(WIN);
    slot = pkt.seq[5:0];
    // below base, past the window end (full width) or duplicate: dropped
    if (pkt.seq < next_expected || {1'b0, pkt.seq} >= win_end || held_map[slot]) return;
    held_map[slot] = 1'b1;
    held_tag[slot] = pkt.payload_tag;
    held_count++;
    // deliver the contiguous run at the base, oldest first
    while (held_map[next_expected[5:0]] && run_seq.size() < WIN) begin
      run_seq = {run_seq, next_expected};
      run_tag = {run_tag, held_tag[next_expected[5:0]]};
      held_map[next_expected[5:0]] = 1'b0;
      held_count--;
      next_expected++;
    end
    // bit i of the sack map is sequence base+i
    for (int i = 0; i < WIN; i++) begin
      sack[i] = held_map[6'(next_expected[5:0] + 6'(i))];
    end
    total = (run_seq.size() == 0) ? 1 : run_seq.size();
    for (int k = 0; k < total; k++) begin
      beat.deliver        = (run_seq.size() != 0);
      beat.delivered_seq  = beat.deliver ? run_seq[k] : '0;
      beat.delivered_tag  = beat.deliver ? run_tag[k] : '0;
      beat.cumulative_ack = next_expected - 32'd1;
      beat.ack_bitmap     = sack;
      beat.window_free    = 7'(WIN) - held_count;
      beat.last           = (k == total - 1);
      delivery_q = {delivery_q, beat};
    end
  endtask

  task automatic queue_packet(input logic [31:0] seq, input logic [31:0] tag);
    srrw_pkg::in_beat_t pkt;
    pkt.seq = seq;
    pkt.payload_tag = tag;
    packet_q = {packet_q, pkt};
    if (seq >= plan_base && {1'b0, seq} < {1'b0, plan_base} + 33'(WIN)
        && !plan_held[seq[5:0]]) begin
      plan_held[seq[5:0]] = 1'b1;
      while (plan_held[plan_base[5:0]]) begin
        plan_held[plan_base[5:0]] = 1'b0;
        plan_base++;
      end
    end
  endtask

  // mostly packets inside the window near the base, some stale, late or wild
  task automatic queue_random_packets(input int count);
    int pick;
    logic [31:0] seq;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        seq = plan_base + $urandom_range(0, 7);
      end else if (pick < 75) begin
        seq = plan_base + $urandom_range(0, WIN - 1);
      end else if (pick < 85) begin
        seq = (plan_base == 0) ? 32'd0 : 32'($urandom_range(0, plan_base - 1));
      end else if (pick < 92) begin
        seq = plan_base + WIN + $urandom_range(0, 20);
      end else begin
        seq = $urandom();
      end
      queue_packet(seq, $urandom());
    end
  endtask

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // sender: presents queued packets, holds a stalled beat, idles between packets
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) begin
        window_accept(in_beat);
        packets_taken++;
        if ($urandom_range(0, 19) == 0) in_calm = !in_calm;
        in_wait = draw_wait(in_calm);
      end
      if (!in_valid || !in_stall_o) begin
        if (in_wait != 0) begin
          in_wait--;
          in_valid <= 1'b0;
        end else if (packet_q.size() != 0) begin
          in_beat <= packet_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks every taken result beat, then stalls for a randomly drawn wait
  always @(posedge clk_i) begin
    srrw_pkg::out_beat_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (delivery_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h", $time, out_beat_o);
          mismatches++;
        end else begin
          want = delivery_q.pop_front();
          check_field("deliver", 64'(want.deliver), 64'(out_beat_o.deliver));
          check_field("delivered_seq", 64'(want.delivered_seq), 64'(out_beat_o.delivered_seq));
          check_field("delivered_tag", 64'(want.delivered_tag), 64'(out_beat_o.delivered_tag));
          check_field("cumulative_ack", 64'(want.cumulative_ack),
                      64'(out_beat_o.cumulative_ack));
          check_field("ack_bitmap", want.ack_bitmap, out_beat_o.ack_bitmap);
          check_field("window_free", 64'(want.window_free), 64'(out_beat_o.window_free));
          check_field("last", 64'(want.last), 64'(out_beat_o.last));
        end
        if ($urandom_range(0, 19) == 0) out_calm = !out_calm;
        out_wait = draw_wait(out_calm);
      end
      if (out_wait != 0) begin
        out_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    logic [31:0] fill_base;
    logic [31:0] order [63];
    logic [31:0] swap;
    int j;

    // directed: in-order start, duplicates, stale and out-of-window packets
    queue_packet(32'd0, 32'h0000_0000);           // first in-order packet
    queue_packet(32'd0, 32'hFFFF_FFFF);           // now below the base
    queue_packet(32'd2, 32'hFFFF_FFFF);           // gap, status beat only
    queue_packet(32'd2, 32'h1234_5678);           // duplicate of a buffered one
    queue_packet(32'd64, 32'h8000_0001);          // last slot of the window
    queue_packet(32'd65, 32'h7FFF_FFFE);          // one past the window end
    queue_packet(32'd1, 32'hA5A5_A5A5);           // fills the gap, two deliveries
    queue_packet(32'hFFFF_FFFF, 32'h5A5A_5A5A);   // far past the window
    queue_packet(32'h8000_0000, 32'hDEAD_BEEF);
    queue_packet(32'd0, 32'h0F0F_0F0F);           // stale
    queue_packet(32'd3, 32'hF0F0_F0F0);
    queue_packet(32'd5, 32'h0000_FFFF);
    queue_packet(32'd4, 32'hFFFF_0000);
    queue_random_packets(50);

    // fill every slot but the base out of order, then release the whole window with the base packet
    fill_base = plan_base;
    for (int i = 0; i < 63; i++) order[i] = fill_base + 32'(i + 1);
    for (int i = 62; i > 0; i--) begin
      j = $urandom_range(0, i);
      swap = order[i];
      order[i] = order[j];
      order[j] = swap;
    end
    for (int i = 0; i < 63; i++) queue_packet(order[i], $urandom());
    queue_packet(fill_base, $urandom());

    queue_random_packets(50);
    packets_planned = packet_q.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (packets_taken != packets_planned) @(posedge clk_i);
    while (delivery_q.size() != 0) @(posedge clk_i);
    // room for a late stray beat after the last expected one
    repeat (200) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: filelist.f
hdl/srrw_pkg.sv
hdl/srrw_ram.sv
hdl/selective_repeat_receive_window_core.sv
dv/tb_selective_repeat_receive_window_core.sv
